[rtl/ctt_pkg.sv]
// -----------------------------------------------------------------------------
// ctt_pkg - shared types and constants of the connection throttle table
// Field widths, result status codes, register indexes, entry layout and the
// sequencer state encoding.
// -----------------------------------------------------------------------------
package ctt_pkg;

   localparam int IP_W       = 32;
   localparam int COUNT_W    = 29;
   localparam int HOLD_W     = 37;
   localparam int BASE_W     = 8;
   localparam int ENTRIES_W  = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ADMIT_NEW  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ADMIT_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TICK_DONE  = 2'd3;

   // action codes
   localparam logic ACTION_CONNECT = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_BASE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_CAP = 8'd1;

   localparam logic [BASE_W-1:0]  HOLD_BASE_RESET  = 8'd5;
   localparam logic [COUNT_W-1:0] REPEAT_CAP_RESET = 29'd400000000;

   typedef struct packed {
      logic [IP_W-1:0]    ip;
      logic [COUNT_W-1:0] repeats;
      logic [HOLD_W-1:0]  hold;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

endpackage

[rtl/ctt_channels.sv]
// -----------------------------------------------------------------------------
// ctt_channels - valid/ready channels of the connection throttle table
// Request, response and register-write channels, each with source and sink.
// -----------------------------------------------------------------------------
interface ctt_req_if import ctt_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            action;
   logic [IP_W-1:0] client_ip;

   modport source (output valid, output action, output client_ip, input ready);
   modport sink   (input valid, input action, input client_ip, output ready);
endinterface

interface ctt_rsp_if import ctt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [COUNT_W-1:0]   repeat_count;
   logic [HOLD_W-1:0]    hold_ticks;
   logic [ENTRIES_W-1:0] entries_live;

   modport source (output valid, output status, output repeat_count,
                   output hold_ticks, output entries_live, input ready);
   modport sink   (input valid, input status, input repeat_count,
                   input hold_ticks, input entries_live, output ready);
endinterface

interface ctt_csr_if import ctt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ctt_ram.sv]
// -----------------------------------------------------------------------------
// ctt_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
module ctt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/connection_throttle_table.sv]
// -----------------------------------------------------------------------------
// connection_throttle_table - repeat-connection limiter with hold aging
// Tracks recently seen IPv4 addresses with a repeat count and a hold timer.
// -----------------------------------------------------------------------------
// An item is one transfer on req_chan: a connect (action 0) or a timer tick
// (action 1); each gives exactly one transfer on rsp_chan. The table lives in
// one RAM with a single read port, and a small sequencer walks the live
// entries one per cycle through that port. A connect that misses, or a tick,
// walks all live entries before its result is ready; a connect that hits
// entry k stops the walk there and writes the bumped entry back in ST_UPDATE.
// Results pass through ST_RESP into the output register. req_chan.ready
// is high only while the sequencer is idle; a finished result waits in
// the rsp_chan register and does not stop the next request from being
// taken. A tick compacts the table in place: each surviving entry is
// written back at a lower or equal index while the read side runs
// ahead. Register writes on csr_chan are always taken and must only
// come while the block is idle; indexes beyond the list are ignored.
// -----------------------------------------------------------------------------
module connection_throttle_table import ctt_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   ctt_req_if.sink   req_chan,
   ctt_rsp_if.source rsp_chan,
   ctt_csr_if.sink   csr_chan
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // sequencer and table bookkeeping
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;     // next entry to read
   logic [CNT_W-1:0]   wr_cnt_ff, wr_cnt_in;     // next compaction slot
   logic               pend_ff, pend_in;         // read data valid this cycle
   logic               action_ff, action_in;
   logic [IP_W-1:0]    ip_ff, ip_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   // configuration
   logic [BASE_W-1:0]  hold_base_ff, hold_base_in;
   logic [COUNT_W-1:0] cap_ff, cap_in;

   // finished result, before the output register
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic [HOLD_W-1:0]   res_hold_ff, res_hold_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [HOLD_W-1:0]    rsp_hold_ff, rsp_hold_in;
   logic [ENTRIES_W-1:0] rsp_live_ff, rsp_live_in;

   // RAM side
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   entry_type          ram_wentry;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;

   logic               issue;
   logic [CNT_W-1:0]   chk_idx;
   logic               hit;
   logic [COUNT_W:0]   bump;
   logic [COUNT_W-1:0] cnt_next;
   logic [HOLD_W-1:0]  hold_prod;
   logic               rsp_free;

   ctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // walk the live entries, one read a cycle
   assign issue     = (state_ff == ST_SCAN) && (rd_cnt_ff < live_ff);
   assign ram_re    = issue;
   assign ram_raddr = rd_cnt_ff[IDX_W-1:0];

   // the entry in rd_entry was read at the address before rd_cnt_ff
   assign chk_idx = rd_cnt_ff - CNT_W'(1);
   assign hit     = pend_ff && (action_ff == ACTION_CONNECT) && (rd_entry.ip == ip_ff);

   // saturating count bump, cap may have been lowered below the stored count
   assign bump     = {1'b0, rd_entry.repeats} + (COUNT_W + 1)'(1);
   assign cnt_next = (bump > {1'b0, cap_ff}) ? cap_ff : bump[COUNT_W-1:0];

   // 8 x 29 multiply, fed from the registered count
   assign hold_prod = HOLD_W'(hold_base_ff) * HOLD_W'(cnt_ff);

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      rd_cnt_in     = rd_cnt_ff;
      wr_cnt_in     = wr_cnt_ff;
      pend_in       = 1'b0;
      action_in     = action_ff;
      ip_in         = ip_ff;
      hit_idx_in    = hit_idx_ff;
      cnt_in        = cnt_ff;
      hold_base_in  = hold_base_ff;
      cap_in        = cap_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_hold_in   = res_hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_hold_in   = rsp_hold_ff;
      rsp_live_in   = rsp_live_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wentry    = '0;

      // register writes; unknown indexes drop
      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_HOLD_BASE) begin
            hold_base_in = csr_chan.data[BASE_W-1:0];
         end else if (csr_chan.index == CSR_REPEAT_CAP) begin
            cap_in = csr_chan.data[COUNT_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in = req_chan.action;
               ip_in     = req_chan.client_ip;
               rd_cnt_in = '0;
               wr_cnt_in = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            if (action_ff == ACTION_TICK) begin
               // keep survivors in order, drop entries whose hold ran out
               if (pend_ff && (rd_entry.hold != '0)) begin
                  ram_we             = 1'b1;
                  ram_waddr          = wr_cnt_ff[IDX_W-1:0];
                  ram_wentry.ip      = rd_entry.ip;
                  ram_wentry.repeats = rd_entry.repeats;
                  ram_wentry.hold    = rd_entry.hold - HOLD_W'(1);
                  wr_cnt_in          = wr_cnt_ff + CNT_W'(1);
               end
               if (!pend_ff && !issue) begin
                  live_in       = wr_cnt_ff;
                  res_status_in = STATUS_TICK_DONE;
                  res_count_in  = '0;
                  res_hold_in   = '0;
                  state_in      = ST_RESP;
               end
            end else if (hit) begin
               hit_idx_in = chk_idx[IDX_W-1:0];
               cnt_in     = cnt_next;
               state_in   = ST_UPDATE;
            end else if (!pend_ff && !issue) begin
               if (live_ff == CNT_W'(TABLE_DEPTH)) begin
                  res_status_in = STATUS_ADMIT_FULL;
                  res_count_in  = '0;
                  res_hold_in   = '0;
               end else begin
                  // append the new address
                  ram_we             = 1'b1;
                  ram_waddr          = live_ff[IDX_W-1:0];
                  ram_wentry.ip      = ip_ff;
                  ram_wentry.repeats = '0;
                  ram_wentry.hold    = HOLD_W'(hold_base_ff);
                  live_in            = live_ff + CNT_W'(1);
                  res_status_in      = STATUS_ADMIT_NEW;
                  res_count_in       = '0;
                  res_hold_in        = HOLD_W'(hold_base_ff);
               end
               state_in = ST_RESP;
            end
         end

         ST_UPDATE: begin
            // write back the bumped count and its new hold
            ram_we             = 1'b1;
            ram_waddr          = hit_idx_ff;
            ram_wentry.ip      = ip_ff;
            ram_wentry.repeats = cnt_ff;
            ram_wentry.hold    = hold_prod;
            res_status_in      = STATUS_REJECT;
            res_count_in       = cnt_ff;
            res_hold_in        = hold_prod;
            state_in           = ST_RESP;
         end

         ST_RESP: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               rsp_hold_in   = res_hold_ff;
               rsp_live_in   = ENTRIES_W'(live_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         pend_ff      <= 1'b0;
         hold_base_ff <= HOLD_BASE_RESET;
         cap_ff       <= REPEAT_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         hold_base_ff <= hold_base_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff     <= rd_cnt_in;
      wr_cnt_ff     <= wr_cnt_in;
      action_ff     <= action_in;
      ip_ff         <= ip_in;
      hit_idx_ff    <= hit_idx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_hold_ff   <= res_hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_hold_ff   <= rsp_hold_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.repeat_count = rsp_count_ff;
   assign rsp_chan.hold_ticks   = rsp_hold_ff;
   assign rsp_chan.entries_live = rsp_live_ff;

endmodule

[rtl/ctt_checker.sv]
// -----------------------------------------------------------------------------
// ctt_checker - port-level assertions for the connection throttle table
// Watches the request and response channels, bound to the top level.
// -----------------------------------------------------------------------------
module ctt_checker import ctt_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [COUNT_W-1:0]   rsp_repeat_count,
   input logic [HOLD_W-1:0]    rsp_hold_ticks,
   input logic [ENTRIES_W-1:0] rsp_entries_live
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_repeat_count) && $stable(rsp_hold_ticks)
         && $stable(rsp_entries_live))
      else $error("response changed while stalled");

   // one item at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a tick reports no count and no hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_TICK_DONE)
         |-> (rsp_repeat_count == '0) && (rsp_hold_ticks == '0))
      else $error("tick result carries count or hold");

   // untracked admit only with a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ADMIT_FULL)
         |-> (rsp_entries_live == ENTRIES_W'(TABLE_DEPTH))
            && (rsp_repeat_count == '0) && (rsp_hold_ticks == '0))
      else $error("untracked admit with table not full");

endmodule

bind connection_throttle_table ctt_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_ctt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_repeat_count (rsp_chan.repeat_count),
   .rsp_hold_ticks   (rsp_chan.hold_ticks),
   .rsp_entries_live (rsp_chan.entries_live)
);

[bench/tb_connection_throttle_table.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_connection_throttle_table - self-checking bench for the throttle table
// Drives connects and ticks with random idling and long response stalls.
// Every verdict is predicted from a private copy of the table and the two
// registers, and compared field by field in order of arrival.
// -----------------------------------------------------------------------------
module tb_connection_throttle_table;
   import ctt_pkg::*;

   localparam int TABLE_DEPTH    = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL_MAX       = 128;

   // indexes past the register list; writes to them must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;

   // idling profiles: sender gap / receiver stall percentages
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_RSP    = 2;
   localparam int IDLE_BOTH   = 3;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [COUNT_W-1:0]   repeat_count;
      logic [HOLD_W-1:0]    hold_ticks;
      logic [ENTRIES_W-1:0] entries_live;
   } verdict_type;

   // Private copy of the address table; predicts one verdict per request.
   class verdict_tracker;
      logic [BASE_W-1:0]  hold_base;
      logic [COUNT_W-1:0] repeat_cap;
      logic [IP_W-1:0]    addr_tab  [TABLE_DEPTH];
      logic [COUNT_W-1:0] count_tab [TABLE_DEPTH];
      logic [HOLD_W-1:0]  hold_tab  [TABLE_DEPTH];
      int                 live_entries;
      verdict_type        expected_verdicts [$];
      int                 failures;

      function new();
         hold_base    = HOLD_BASE_RESET;
         repeat_cap   = REPEAT_CAP_RESET;
         live_entries = 0;
         failures     = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_HOLD_BASE:  hold_base  = value[BASE_W-1:0];
            CSR_REPEAT_CAP: repeat_cap = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic action, logic [IP_W-1:0] ip);
         verdict_type      v;
         logic [COUNT_W:0] bumped;
         int               slot;
         int               keep;
         v = '0;
         if (action == ACTION_TICK) begin
            // age every hold; drop entries already at zero, keep order
            keep = 0;
            for (int r = 0; r < live_entries; r++) begin
               if (hold_tab[r] != '0) begin
                  addr_tab[keep]  = addr_tab[r];
                  count_tab[keep] = count_tab[r];
                  hold_tab[keep]  = hold_tab[r] - 1'b1;
                  keep++;
               end
            end
            live_entries = keep;
            v.status = STATUS_TICK_DONE;
         end else begin
            slot = -1;
            for (int i = 0; i < live_entries && slot < 0; i++)
               if (addr_tab[i] == ip) slot = i;
            if (slot >= 0) begin
               bumped = {1'b0, count_tab[slot]} + 1'b1;
               if (bumped > {1'b0, repeat_cap}) bumped = {1'b0, repeat_cap};
               count_tab[slot] = bumped[COUNT_W-1:0];
               hold_tab[slot]  = HOLD_W'(hold_base) * HOLD_W'(count_tab[slot]);
               v.status        = STATUS_REJECT;
               v.repeat_count  = count_tab[slot];
               v.hold_ticks    = hold_tab[slot];
            end else if (live_entries >= TABLE_DEPTH) begin
               v.status = STATUS_ADMIT_FULL;
            end else begin
               addr_tab[live_entries]  = ip;
               count_tab[live_entries] = '0;
               hold_tab[live_entries]  = HOLD_W'(hold_base);
               live_entries++;
               v.status     = STATUS_ADMIT_NEW;
               v.hold_ticks = HOLD_W'(hold_base);
            end
         end
         v.entries_live = ENTRIES_W'(live_entries);
         expected_verdicts.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            $error("verdict with nothing outstanding: status %0d", got.status);
            failures++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, actual %0d",
                   want.repeat_count, got.repeat_count);
            failures++;
         end
         if (got.hold_ticks !== want.hold_ticks) begin
            $error("hold_ticks: expected %0d, actual %0d", want.hold_ticks, got.hold_ticks);
            failures++;
         end
         if (got.entries_live !== want.entries_live) begin
            $error("entries_live: expected %0d, actual %0d",
                   want.entries_live, got.entries_live);
            failures++;
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctt_req_if req_chan ();
   ctt_rsp_if rsp_chan ();
   ctt_csr_if csr_chan ();

   verdict_tracker tracker;
   int             send_gap_pct  = 0;
   int             rsp_stall_pct = 0;
   int             rsp_hold_left = 0;
   int             quiet_cycles  = 0;
   logic [IP_W-1:0] ip_pool [POOL_MAX];

   connection_throttle_table #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: a long hold-off, when requested, wins over random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: check the verdict first, then apply register writes and
   // predict new requests, so a same-edge transfer never jumps the queue.
   always @(posedge clock) begin
      verdict_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status       = rsp_chan.status;
            got.repeat_count = rsp_chan.repeat_count;
            got.hold_ticks   = rsp_chan.hold_ticks;
            got.entries_live = rsp_chan.entries_live;
            tracker.check_verdict(got);
         end
         if (csr_chan.valid && csr_chan.ready)
            tracker.write_register(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready)
            tracker.note_request(req_chan.action, req_chan.client_ip);

         // watchdog: count edges with no transfer on any channel
         if ((rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready) ||
             (req_chan.valid && req_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Offer one request; idle first at the current gap rate, then hold
   // valid until the transfer. Valid stays high into the next call.
   task automatic send_item(logic action, logic [IP_W-1:0] ip);
      if ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= action;
      req_chan.client_ip <= ip;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait until every outstanding verdict has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Reprogram both registers with the block idle.
   task automatic configure(logic [CSR_DATA_W-1:0] base, logic [CSR_DATA_W-1:0] cap);
      drain();
      write_reg(CSR_HOLD_BASE, base);
      write_reg(CSR_REPEAT_CAP, cap);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         IDLE_SENDER: begin send_gap_pct = 54; rsp_stall_pct = 0;  end
         IDLE_RSP:    begin send_gap_pct = 0;  rsp_stall_pct = 54; end
         IDLE_BOTH:   begin send_gap_pct = 8;  rsp_stall_pct = 8;  end
         default:     begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   // Random traffic over a fresh address pool: mostly repeat visitors,
   // some one-off addresses, ticks at the given rate.
   task automatic run_phase(int count, int tick_pct, int pool_size, int mode,
                            int pause_at, int hold_off);
      set_idling(mode);
      for (int k = 0; k < POOL_MAX; k++) ip_pool[k] = $urandom();
      rsp_hold_left = hold_off;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) drain();
         if ($urandom_range(99) < tick_pct)
            send_item(ACTION_TICK, $urandom());
         else if ($urandom_range(9) == 0)
            send_item(ACTION_CONNECT, $urandom());
         else
            send_item(ACTION_CONNECT, ip_pool[$urandom_range(pool_size - 1)]);
      end
   endtask

   initial begin
      tracker = new();
      req_chan.valid     <= 1'b0;
      req_chan.action    <= ACTION_CONNECT;
      req_chan.client_ip <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_HOLD_BASE;
      csr_chan.data      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, tick on an empty table, address extremes, repeats
      send_item(ACTION_TICK, $urandom());
      send_item(ACTION_CONNECT, 32'h0000_0000);
      send_item(ACTION_CONNECT, 32'hFFFF_FFFF);
      send_item(ACTION_CONNECT, 32'h0000_0000);
      send_item(ACTION_CONNECT, 32'h0000_0000);
      send_item(ACTION_TICK, 32'hFFFF_FFFF);

      // writes past the register list must change nothing
      drain();
      write_reg(CSR_UNUSED_LO, 32'h0000_0001);
      write_reg(CSR_UNUSED_HI, 32'hFFFF_FFFF);

      // widest base (upper data bits dropped) and a cap below a live count
      configure(32'h0000_01FF, 32'd1);
      send_item(ACTION_CONNECT, 32'h0000_0000);
      send_item(ACTION_CONNECT, 32'hFFFF_FFFF);

      // zero cap and zero base: holds go to zero and the next tick evicts
      configure(32'd0, 32'd0);
      send_item(ACTION_CONNECT, 32'h0000_0000);
      send_item(ACTION_CONNECT, 32'h1234_5678);
      send_item(ACTION_TICK, 32'h5555_AAAA);
      send_item(ACTION_CONNECT, 32'h1234_5678);
      send_item(ACTION_TICK, 32'hAAAA_5555);

      // all-ones writes: base keeps its low 8 bits (255), cap the full 29 bits
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACTION_CONNECT, 32'h8000_0000);
      send_item(ACTION_CONNECT, 32'h7FFF_FFFF);
      send_item(ACTION_CONNECT, 32'h8000_0000);
      send_item(ACTION_TICK, $urandom());

      // Random phases: (items, tick %, pool, idling, pause point, hold-off)
      configure(32'd5, 32'd400000000);
      run_phase(180, 20, 24, IDLE_NONE, -1, 0);
      configure(32'd1, 32'd3);
      run_phase(180, 30, 12, IDLE_SENDER, -1, 0);
      configure(32'd0, 32'd1);
      run_phase(180, 25, 10, IDLE_RSP, -1, 0);
      // hold the sender mid-phase until the block has emptied
      configure(32'd3, 32'h1FFF_FFFF);
      run_phase(180, 15, 8, IDLE_BOTH, 90, 0);
      // flood with new addresses to fill the table; stall the response
      // side long enough that the block backs up into its request port
      configure(32'd40, 32'd2);
      run_phase(180, 2, 100, IDLE_NONE, -1, 400);
      // tick-heavy traffic ages the full table back down
      configure(32'd1, 32'd400000000);
      run_phase(180, 50, 20, IDLE_RSP, -1, 0);

      drain();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
